>>> hdl/wakeup_radio_mac_controller_top_macros.svh
// Assertion macros shared by the wake-up radio MAC controller RTL.
`ifndef WAKEUP_RADIO_MAC_CONTROLLER_TOP_MACROS_SVH
`define WAKEUP_RADIO_MAC_CONTROLLER_TOP_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define WRMC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wrmc_pkg.sv
// Types, codes and constants of the wake-up radio MAC controller.
`timescale 1ns / 1ps
package wrmc_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned NumRes        = 5;
  localparam int unsigned ResCntW       = 3;
  localparam int unsigned WinW          = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam logic [WinW-1:0] WinReset  = 16'd1000;
  localparam int unsigned QueuedW       = 7;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ENQ       = 3'd1,
    CMD_WTX_OK    = 3'd2,
    CMD_WRX_START = 3'd3,
    CMD_WRX_OK    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WTX  = 3'd1,
    MODE_WRX  = 3'd2,
    MODE_DTX  = 3'd3,
    MODE_DRX  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ACT_WTX = 3'd0,
    ACT_WRX = 3'd1,
    ACT_DTX = 3'd2,
    ACT_DRX = 3'd3,
    ACT_OFF = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TX_WAKE = 2'd0,
    CFG_RX_WAKE = 2'd1,
    CFG_DATA_TX = 2'd2,
    CFG_DATA_RX = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WinW-1:0] tx_wake;
    logic [WinW-1:0] rx_wake;
    logic [WinW-1:0] data_tx;
    logic [WinW-1:0] data_rx;
  } win_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] wake_seq;
    logic        wake_seq_given;
    logic        wake_off;
    logic        main_off;
  } ev_t;

  typedef struct packed {
    action_e             action;
    logic [15:0]         seq;
    logic                seq_vld;
    mode_e               mode;
    logic [QueuedW-1:0]  queued;
    logic                dropped;
  } res_t;

  typedef struct packed {
    logic [ResCntW-1:0]  cnt;
    res_t [NumRes-1:0]   r;
  } res_set_t;

endpackage

>>> hdl/wrmc_cfg.sv
// Window register file; a zero window loads its timer with one.
`timescale 1ns / 1ps
module wrmc_cfg
  import wrmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [WinW-1:0]    wdata_i,
  output win_t               load_o
);

  win_t win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{WinReset, WinReset, WinReset, WinReset};
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_TX_WAKE: win_q.tx_wake <= wdata_i;
        CFG_RX_WAKE: win_q.rx_wake <= wdata_i;
        CFG_DATA_TX: win_q.data_tx <= wdata_i;
        CFG_DATA_RX: win_q.data_rx <= wdata_i;
        default: ;
      endcase
    end
  end

  function automatic logic [WinW-1:0] fix0(logic [WinW-1:0] w);
    return (w == '0) ? WinW'(1) : w;
  endfunction

  assign load_o.tx_wake = fix0(win_q.tx_wake);
  assign load_o.rx_wake = fix0(win_q.rx_wake);
  assign load_o.data_tx = fix0(win_q.data_tx);
  assign load_o.data_rx = fix0(win_q.data_rx);

endmodule

>>> hdl/wrmc_core.sv
// Mode, queue count and timers; evaluates one event into its result set.
`timescale 1ns / 1ps
`include "wakeup_radio_mac_controller_top_macros.svh"
module wrmc_core
  import wrmc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     beat_i,
  input  ev_t      ev_i,
  input  win_t     win_i,
  output res_set_t set_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(QueueDepth);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] pw_q, pw_d;
  logic [WinW-1:0] tx_q, tx_d, rx_q, rx_d, dtx_q, dtx_d, drx_q, drx_d;
  logic            drop;

  function automatic res_t mk(action_e a, logic [15:0] s, logic v, mode_e md,
                              logic [QueuedW-1:0] qd, logic d);
    res_t r;
    r.action  = a;
    r.seq     = s;
    r.seq_vld = v;
    r.mode    = md;
    r.queued  = qd;
    r.dropped = d;
    return r;
  endfunction

  // queue count after the event
  always_comb begin
    pw_d = pw_q;
    drop = 1'b0;
    if (ev_i.cmd == CMD_ENQ) begin
      if (pw_q < CntMax) pw_d = pw_q + CntW'(1);
      else drop = 1'b1;
    end else if (ev_i.cmd == CMD_WTX_OK && mode_q == MODE_WTX && tx_q != '0 &&
                 !ev_i.main_off && pw_q != '0) begin
      pw_d = pw_q - CntW'(1);
    end
  end

  always_comb begin
    logic               e_tx, e_rx, e_dtx, e_drx;
    logic [CntW+6:0]    ext;
    logic [QueuedW-1:0] qd;
    logic [ResCntW-1:0] n;
    logic               can_wtx;
    ext     = {{QueuedW{1'b0}}, pw_d};
    qd      = ext[QueuedW-1:0];
    n       = '0;
    set_o   = '0;
    mode_d  = mode_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    dtx_d   = dtx_q;
    drx_d   = drx_q;
    can_wtx = !ev_i.wake_off;
    e_tx    = 1'b0;
    e_rx    = 1'b0;
    e_dtx   = 1'b0;
    e_drx   = 1'b0;
    unique case (ev_i.cmd)
      CMD_TICK: begin
        e_tx  = (tx_q == WinW'(1));
        e_rx  = (rx_q == WinW'(1));
        e_dtx = (dtx_q == WinW'(1));
        e_drx = (drx_q == WinW'(1));
        if (tx_q != '0) tx_d = tx_q - WinW'(1);
        if (rx_q != '0) rx_d = rx_q - WinW'(1);
        if (dtx_q != '0) dtx_d = dtx_q - WinW'(1);
        if (drx_q != '0) drx_d = drx_q - WinW'(1);
        if (e_tx && (mode_d == MODE_WTX || mode_d == MODE_IDLE) && pw_q != '0 &&
            can_wtx) begin
          tx_d = win_i.tx_wake;
          mode_d = MODE_WTX;
          set_o.r[n] = mk(ACT_WTX, 16'd0, 1'b0, mode_d, qd, 1'b0);
          n = n + ResCntW'(1);
        end
        if (e_rx && (mode_d == MODE_WRX || mode_d == MODE_IDLE)) begin
          mode_d = MODE_IDLE;
          set_o.r[n] = mk(ACT_OFF, 16'd0, 1'b0, mode_d, qd, 1'b0);
          n = n + ResCntW'(1);
        end
        if (e_dtx) begin
          mode_d = MODE_IDLE;
          set_o.r[n] = mk(ACT_OFF, 16'd0, 1'b0, mode_d, qd, 1'b0);
          n = n + ResCntW'(1);
          if (pw_q != '0 && can_wtx) begin
            tx_d = win_i.tx_wake;
            mode_d = MODE_WTX;
            set_o.r[n] = mk(ACT_WTX, 16'd0, 1'b0, mode_d, qd, 1'b0);
            n = n + ResCntW'(1);
          end
        end
        if (e_drx && mode_d == MODE_DRX) begin
          mode_d = MODE_IDLE;
          set_o.r[n] = mk(ACT_OFF, 16'd0, 1'b0, mode_d, qd, 1'b0);
          n = n + ResCntW'(1);
        end
      end
      CMD_ENQ: begin
        if (mode_q == MODE_IDLE && can_wtx) begin
          tx_d = win_i.tx_wake;
          mode_d = MODE_WTX;
          set_o.r[n] = mk(ACT_WTX, ev_i.wake_seq_given ? ev_i.wake_seq : 16'd0,
                          ev_i.wake_seq_given, mode_d, qd, drop);
          n = n + ResCntW'(1);
        end
      end
      CMD_WTX_OK: begin
        if (mode_q == MODE_WTX && tx_q != '0) begin
          tx_d = '0;
          if (!ev_i.main_off) begin
            dtx_d = win_i.data_tx;
            mode_d = MODE_DTX;
            set_o.r[n] = mk(ACT_DTX, 16'd0, 1'b0, mode_d, qd, 1'b0);
            n = n + ResCntW'(1);
          end
        end
      end
      CMD_WRX_START: begin
        rx_d = win_i.rx_wake;
        mode_d = MODE_WRX;
        set_o.r[n] = mk(ACT_WRX, 16'd0, 1'b0, mode_d, qd, 1'b0);
        n = n + ResCntW'(1);
      end
      CMD_WRX_OK: begin
        if (mode_q == MODE_WRX && rx_q != '0) begin
          rx_d = '0;
          drx_d = win_i.data_rx;
          mode_d = MODE_DRX;
          set_o.r[n] = mk(ACT_DRX, 16'd0, 1'b0, mode_d, qd, 1'b0);
          n = n + ResCntW'(1);
        end
      end
      default: ;
    endcase
    set_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pw_q   <= '0;
      tx_q   <= '0;
      rx_q   <= '0;
      dtx_q  <= '0;
      drx_q  <= '0;
    end else if (beat_i) begin
      mode_q <= mode_d;
      pw_q   <= pw_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      dtx_q  <= dtx_d;
      drx_q  <= drx_d;
    end
  end

  `WRMC_ASSERT(a_cnt_range, pw_q <= CntMax, "queue count above depth")
  `WRMC_ASSERT(a_set_size, set_o.cnt <= ResCntW'(NumRes), "result set too large")
  `WRMC_ASSERT_NEXT(a_wrx_start, beat_i && ev_i.cmd == CMD_WRX_START,
                    mode_q == MODE_WRX && rx_q != '0, "wake rx start not taken")
  `WRMC_ASSERT_NEXT(a_drop_full, beat_i && drop, pw_q == CntMax,
                    "drop with room in queue")

endmodule

>>> hdl/wrmc_seq.sv
// Result sequencer: an active result set drains one beat per cycle while ready_i is high, one set waits behind it.
`timescale 1ns / 1ps
`include "wakeup_radio_mac_controller_top_macros.svh"
module wrmc_seq
  import wrmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  res_set_t set_i,
  output logic     ready_o,
  output logic     valid_o,
  input  logic     ready_i,
  output res_t     res_o,
  output logic     last_o
);

  res_t [NumRes-1:0]  act_q;
  res_t [NumRes-1:0]  hold_q;
  logic [ResCntW-1:0] act_cnt_q, hold_cnt_q, ptr_q;
  logic               hold_vld_q;
  logic               busy, pop, done;

  assign busy    = (ptr_q != act_cnt_q);
  assign pop     = busy && ready_i;
  assign last_o  = (ptr_q == act_cnt_q - ResCntW'(1));
  assign done    = !busy || (pop && last_o);
  assign ready_o = !hold_vld_q;
  assign valid_o = busy;
  assign res_o   = act_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q  <= '0;
      hold_cnt_q <= '0;
      ptr_q      <= '0;
      hold_vld_q <= 1'b0;
    end else begin
      if (done && hold_vld_q) begin
        act_q      <= hold_q;
        act_cnt_q  <= hold_cnt_q;
        ptr_q      <= '0;
        hold_vld_q <= 1'b0;
      end else if (done && push_i) begin
        act_q     <= set_i.r;
        act_cnt_q <= set_i.cnt;
        ptr_q     <= '0;
      end else begin
        if (pop) ptr_q <= ptr_q + ResCntW'(1);
        if (push_i) begin
          hold_q     <= set_i.r;
          hold_cnt_q <= set_i.cnt;
          hold_vld_q <= 1'b1;
        end
      end
    end
  end

  `WRMC_ASSERT(a_ptr_range, ptr_q <= act_cnt_q, "read pointer past set end")
  `WRMC_ASSERT(a_cnt_range, act_cnt_q <= ResCntW'(NumRes) &&
               hold_cnt_q <= ResCntW'(NumRes), "set count too large")
  `WRMC_ASSERT_NEXT(a_hold_drain, hold_vld_q && done, !hold_vld_q && ptr_q == '0,
                    "waiting set not moved up")

endmodule

>>> hdl/wakeup_radio_mac_controller_top.sv
// Top level of the wake-up radio MAC controller.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser cmd, tdata flags and wake seq
//   m_axis    out  m_axis_tvalid/m_axis_tready  tuser action, tdata result, tlast
//   cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// An event beat updates mode, queue and timers in the cycle it is taken.
// It yields zero to three result beats, sent one per cycle while m_axis_tready is high, from a registered set.
// One set drains while the next waits, so input stalls only with both held.
// Reset: idle, empty queue, timers stopped, windows 1000; no clearing pass.
`timescale 1ns / 1ps
module wakeup_radio_mac_controller_top
  import wrmc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // wake_seq, wake_seq_given,
                                             // wake_radio_disabled, main_radio_disabled
  input  logic [2:0]         s_axis_tuser,   // cmd
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // seq_out, seq_out_valid, mode_now,
                                             // queued, dropped
  output logic [2:0]         m_axis_tuser,   // action
  output logic               m_axis_tlast,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WinW-1:0]    cfg_wdata_i
);

  win_t     win;
  ev_t      ev;
  res_set_t set;
  res_t     res;
  logic     beat;

  assign beat              = s_axis_tvalid && s_axis_tready;
  assign ev.cmd            = s_axis_tuser;
  assign ev.wake_seq       = s_axis_tdata[15:0];
  assign ev.wake_seq_given = s_axis_tdata[16];
  assign ev.wake_off       = s_axis_tdata[17];
  assign ev.main_off       = s_axis_tdata[18];

  wrmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .load_o  (win)
  );

  wrmc_core #(
    .QueueDepth (QueueDepth)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .ev_i   (ev),
    .win_i  (win),
    .set_o  (set)
  );

  wrmc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (beat),
    .set_i   (set),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = res.action;
  assign m_axis_tdata = {4'b0, res.dropped, res.queued, res.mode, res.seq_vld, res.seq};

endmodule

>>> tb/tb.sv
// Self-checking testbench for the wake-up radio MAC controller: random and directed events against a predictor.
`timescale 1ns / 1ps
module tb;
  import wrmc_pkg::*;

  localparam int unsigned RunLimit = 200000;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] seq;
    logic        given;
    logic        wake_off;
    logic        main_off;
  } mac_ev_t;

  typedef struct packed {
    action_e             action;
    logic [15:0]         seq;
    logic                seq_vld;
    mode_e               mode;
    logic [QueuedW-1:0]  queued;
    logic                dropped;
    logic                is_last;
  } mac_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic [2:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [WinW-1:0]    cfg_wdata_i = '0;

  wakeup_radio_mac_controller_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  mac_ev_t   ev_q[$];
  mac_beat_t action_q[$];
  mac_beat_t batch_q[$];
  int        ev_pushed = 0;
  int        ev_taken = 0;
  int        mismatches = 0;
  int        run_cycles = 0;

  // Predictor state
  logic [WinW-1:0] win [4];
  mode_e           mac_mode;
  int unsigned     pkts;
  logic [15:0]     tmr_txw, tmr_rxw, tmr_dtx, tmr_drx;
  logic            drop_now;
  logic            wake_off_now;

  initial begin
    for (int i = 0; i < 4; i++) win[i] = WinReset;
    mac_mode = MODE_IDLE;
    pkts = 0;
    tmr_txw = '0;
    tmr_rxw = '0;
    tmr_dtx = '0;
    tmr_drx = '0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] window_load(logic [15:0] w);
    return (w == '0) ? 16'd1 : w;
  endfunction

  task automatic add_beat(action_e act, logic [15:0] s, logic v);
    mac_beat_t b;
    b.action  = act;
    b.seq     = s;
    b.seq_vld = v;
    b.mode    = mac_mode;
    b.queued  = pkts[QueuedW-1:0];
    b.dropped = drop_now;
    b.is_last = 1'b0;
    if (batch_q.size() < NumRes) batch_q.insert(batch_q.size(), b);
  endtask

  task automatic launch_wake_tx(logic [15:0] s, logic v);
    if (!wake_off_now) begin
      tmr_txw  = window_load(win[CFG_TX_WAKE]);
      mac_mode = MODE_WTX;
      add_beat(ACT_WTX, v ? s : 16'd0, v);
    end
  endtask

  task automatic radio_off();
    mac_mode = MODE_IDLE;
    add_beat(ACT_OFF, 16'd0, 1'b0);
  endtask

  task automatic predict_event(mac_ev_t ev);
    logic e_tx, e_rx, e_dtx, e_drx;
    batch_q.delete();
    drop_now     = 1'b0;
    wake_off_now = ev.wake_off;
    case (ev.cmd)
      CMD_TICK: begin
        e_tx  = (tmr_txw == 16'd1);
        e_rx  = (tmr_rxw == 16'd1);
        e_dtx = (tmr_dtx == 16'd1);
        e_drx = (tmr_drx == 16'd1);
        if (tmr_txw != '0) tmr_txw = tmr_txw - 16'd1;
        if (tmr_rxw != '0) tmr_rxw = tmr_rxw - 16'd1;
        if (tmr_dtx != '0) tmr_dtx = tmr_dtx - 16'd1;
        if (tmr_drx != '0) tmr_drx = tmr_drx - 16'd1;
        if (e_tx && (mac_mode == MODE_WTX || mac_mode == MODE_IDLE) && pkts > 0)
          launch_wake_tx(16'd0, 1'b0);
        if (e_rx && (mac_mode == MODE_WRX || mac_mode == MODE_IDLE)) radio_off();
        if (e_dtx) begin
          radio_off();
          if (pkts > 0) launch_wake_tx(16'd0, 1'b0);
        end
        if (e_drx && mac_mode == MODE_DRX) radio_off();
      end
      CMD_ENQ: begin
        if (pkts < QueueDepthDef) pkts++;
        else drop_now = 1'b1;
        if (mac_mode == MODE_IDLE) launch_wake_tx(ev.seq, ev.given);
      end
      CMD_WTX_OK: begin
        if (mac_mode == MODE_WTX && tmr_txw != '0) begin
          tmr_txw = '0;
          if (!ev.main_off) begin
            tmr_dtx  = window_load(win[CFG_DATA_TX]);
            mac_mode = MODE_DTX;
            if (pkts > 0) pkts--;
            add_beat(ACT_DTX, 16'd0, 1'b0);
          end
        end
      end
      CMD_WRX_START: begin
        tmr_rxw  = window_load(win[CFG_RX_WAKE]);
        mac_mode = MODE_WRX;
        add_beat(ACT_WRX, 16'd0, 1'b0);
      end
      CMD_WRX_OK: begin
        if (mac_mode == MODE_WRX && tmr_rxw != '0) begin
          tmr_rxw  = '0;
          tmr_drx  = window_load(win[CFG_DATA_RX]);
          mac_mode = MODE_DRX;
          add_beat(ACT_DRX, 16'd0, 1'b0);
        end
      end
      default: ;
    endcase
    if (batch_q.size() > 0) batch_q[batch_q.size()-1].is_last = 1'b1;
    foreach (batch_q[i]) action_q.insert(action_q.size(), batch_q[i]);
  endtask

  // Event driver: bursts of random length, random gaps
  mac_ev_t cur_ev;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(cur_ev);
        ev_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (ev_q.size() != 0) begin
          cur_ev = ev_q.pop_front();
          s_axis_tdata  <= {5'b0, cur_ev.main_off, cur_ev.wake_off, cur_ev.given, cur_ev.seq};
          s_axis_tuser  <= cur_ev.cmd;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern
  mac_beat_t   got_beat;
  mac_beat_t   exp_beat;
  logic [5:0]  rdy_cnt = '0;
  int          rdy_style = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat.action  = action_e'(m_axis_tuser);
        got_beat.seq     = m_axis_tdata[15:0];
        got_beat.seq_vld = m_axis_tdata[16];
        got_beat.mode    = mode_e'(m_axis_tdata[19:17]);
        got_beat.queued  = m_axis_tdata[26:20];
        got_beat.dropped = m_axis_tdata[27];
        got_beat.is_last = m_axis_tlast;
        if (action_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: act %0d", got_beat.action);
        end else begin
          exp_beat = action_q.pop_front();
          if (got_beat != exp_beat) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch got: act %0d seq %h v %0d mode %0d q %0d drop %0d last %0d",
                       got_beat.action, got_beat.seq, got_beat.seq_vld, got_beat.mode,
                       got_beat.queued, got_beat.dropped, got_beat.is_last);
              $display("    expected: act %0d seq %h v %0d mode %0d q %0d drop %0d last %0d",
                       exp_beat.action, exp_beat.seq, exp_beat.seq_vld, exp_beat.mode,
                       exp_beat.queued, exp_beat.dropped, exp_beat.is_last);
            end
          end
        end
      end
      rdy_cnt <= rdy_cnt + 6'd1;
      if (rdy_cnt == '0) rdy_style = $urandom_range(0, 2);
      case (rdy_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rdy_cnt[1:0] != 2'd0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles > RunLimit) begin
      $display("FAIL wakeup_radio_mac_controller_top");
      $finish;
    end
  end

  task automatic push_ev(logic [2:0] c, logic [15:0] s, logic g, logic wo, logic mo);
    mac_ev_t ev;
    ev.cmd      = c;
    ev.seq      = s;
    ev.given    = g;
    ev.wake_off = wo;
    ev.main_off = mo;
    ev_q.insert(ev_q.size(), ev);
    ev_pushed++;
  endtask

  function automatic logic rare_flag();
    return ($urandom_range(0, 7) == 0);
  endfunction

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      push_ev(CMD_TICK, 16'($urandom), 1'($urandom), rare_flag(), rare_flag());
  endtask

  task automatic push_enq();
    push_ev(CMD_ENQ, 16'($urandom), 1'($urandom), rare_flag(), rare_flag());
  endtask

  // Mostly well-formed wake tx / wake rx flows and enqueue bursts; the rest is single noise events
  task automatic push_random(int n, bit enq_heavy);
    int made;
    int pick;
    int k;
    int j;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        k = $urandom_range(0, 19);
        if (k == 0) push_ev(3'($urandom_range(int'(CMD_WRX_OK) + 1, 7)), 16'($urandom),
                            1'($urandom), 1'($urandom), 1'($urandom));
        else begin
          push_ev(3'($urandom_range(0, int'(CMD_WRX_OK))), 16'($urandom), 1'($urandom),
                  rare_flag(), rare_flag());
        end
        made++;
      end else if (pick < 6) begin
        push_enq();
        k = $urandom_range(0, 3);
        push_ticks(k);
        push_ev(CMD_WTX_OK, 16'($urandom), 1'($urandom), rare_flag(), rare_flag());
        j = $urandom_range(0, 4);
        push_ticks(j);
        made += k + j + 2;
      end else if (pick < 8) begin
        push_ev(CMD_WRX_START, 16'($urandom), 1'($urandom), rare_flag(), rare_flag());
        k = $urandom_range(0, 2);
        push_ticks(k);
        push_ev(CMD_WRX_OK, 16'($urandom), 1'($urandom), rare_flag(), rare_flag());
        j = $urandom_range(0, 4);
        push_ticks(j);
        made += k + j + 2;
      end else begin
        k = enq_heavy ? $urandom_range(4, 12) : $urandom_range(1, 6);
        for (int i = 0; i < k; i++) push_enq();
        made += k;
      end
    end
  endtask

  task automatic wait_drained();
    while (ev_taken != ev_pushed) @(posedge clk_i);
    while (action_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_windows(logic [15:0] txw, logic [15:0] rxw, logic [15:0] dtx,
                               logic [15:0] drx);
    logic [15:0] vals [4];
    vals = '{txw, rxw, dtx, drx};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      win[i] = vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_random(15, 1'b0);
    wait_drained();

    // Directed: zero windows so every timer expires on the next tick
    write_windows(16'd0, 16'd0, 16'd0, 16'd0);
    push_ev(CMD_ENQ, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_ev(CMD_ENQ, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_WTX_OK, 16'h0000, 1'b0, 1'b0, 1'b1);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_WTX_OK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_WRX_START, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    push_ev(CMD_WRX_OK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_WRX_OK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_ENQ, 16'hA5A5, 1'b1, 1'b1, 1'b0);
    push_ev(CMD_ENQ, 16'h5A5A, 1'b1, 1'b0, 1'b0);
    push_ev(CMD_WTX_OK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    for (int c = int'(CMD_WRX_OK) + 1; c < 8; c++) push_ev(3'(c), 16'hFFFF, 1'b1, 1'b1, 1'b1);
    push_ev(CMD_WTX_OK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_WRX_START, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_ev(CMD_WRX_START, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_ev(CMD_ENQ, 16'h0000, 1'b0, 1'b0, 1'b0);
    wait_drained();

    write_windows(16'd1, 16'd2, 16'd3, 16'd4);
    push_random(30, 1'b0);
    wait_drained();

    // Enqueue-heavy: drive the count into saturation
    write_windows(16'd2, 16'd1, 16'd1, 16'd3);
    push_random(50, 1'b1);
    wait_drained();

    write_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(15, 1'b0);
    wait_drained();

    write_windows(16'd0, 16'd3, 16'hFFFF, 16'd1);
    push_random(25, 1'b0);
    wait_drained();

    write_windows(16'd5, 16'd4, 16'd6, 16'd2);
    push_random(30, 1'b1);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && action_q.size() == 0) begin
      $display("PASS wakeup_radio_mac_controller_top");
    end else begin
      $display("FAIL wakeup_radio_mac_controller_top");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/wrmc_pkg.sv
hdl/wrmc_cfg.sv
hdl/wrmc_core.sv
hdl/wrmc_seq.sv
hdl/wakeup_radio_mac_controller_top.sv
tb/tb.sv
